/* hdl/snap_frame_receiver_core_defines.svh */
// Assertion macros shared by the receiver RTL.
`ifndef SNAP_FRAME_RECEIVER_CORE_DEFINES_SVH
`define SNAP_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define SNAPFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("snapfr check failed");

// Checked at every edge, reset included.
`define SNAPFR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("snapfr check failed");

`else

`define SNAPFR_ASSERT(lbl, prop)
`define SNAPFR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* hdl/snapfr_pkg.sv */
package snapfr_pkg;

    localparam int PAYLOAD_DEPTH = 16;
    localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
    localparam int LEN_W         = 5;
    localparam int BIDX_W        = 5;
    localparam int ACK_BEATS     = 6;
    localparam int BEAT_W        = 3;

    // Input opcodes
    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [1:0] CFG_SYNC_BYTE  = 2'd2;

    // Header checks and ack frame bytes
    localparam logic [7:0] HDB2_MASK    = 8'hfc;
    localparam logic [7:0] HDB2_VAL     = 8'h50;
    localparam logic [7:0] HDB1_MASK    = 8'hf0;
    localparam logic [7:0] HDB1_VAL     = 8'h30;
    localparam logic [1:0] ACK_REQ_CODE = 2'b01;
    localparam logic [7:0] ACK_HDB2     = 8'h52;
    localparam logic [7:0] NAK_HDB2     = 8'h53;
    localparam logic [7:0] ACK_HDB1     = 8'h30;

    localparam logic [7:0] CRC_FOLD [8] = '{
        8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
    };

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_SYNC = 7'b0000010,
        PH_HDB2 = 7'b0000100,
        PH_HDB1 = 7'b0001000,
        PH_DAB  = 7'b0010000,
        PH_DATA = 7'b0100000,
        PH_CRC  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic             clr;
        logic             we;
        logic [IDX_W-1:0] widx;
        logic [7:0]       wdata;
        logic             re;
        logic             rd_ok;
        logic [IDX_W-1:0] ridx;
    } t_buf_ctrl;

    // Reflected CRC-8, one byte: fold each set bit of crc^b through the table.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] r;
        x = b ^ crc;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                r = r ^ CRC_FOLD[i];
            end
        end
        return r;
    endfunction

endpackage

/* hdl/snapfr_payload_buf.sv */
`include "snap_frame_receiver_core_defines.svh"

module snapfr_payload_buf
    import snapfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_buf_ctrl i_ctrl,
    output logic [7:0] o_rd_byte
);

    logic [7:0]               r_mem [PAYLOAD_DEPTH];
    logic [PAYLOAD_DEPTH-1:0] r_written;
    logic [7:0]               r_rd_data;
    logic                     r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_ctrl.widx] <= i_ctrl.wdata;
        end
        if (i_ctrl.re) begin
            r_rd_data <= r_mem[i_ctrl.ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_written <= '0;
            end else if (i_ctrl.we) begin
                r_written[i_ctrl.widx] <= 1'b1;
            end
            if (i_ctrl.re) begin
                r_rd_hit <= i_ctrl.rd_ok && r_written[i_ctrl.ridx];
            end
        end
    end

    // Entries never written since the last clear read as zero.
    assign o_rd_byte = r_rd_hit ? r_rd_data : 8'h00;

    `SNAPFR_ASSERT(a_clr_empties, i_ctrl.clr |=> (r_written == '0))
    `SNAPFR_ASSERT(a_we_marks, i_ctrl.we |=> r_written[$past(i_ctrl.widx)])
    `SNAPFR_ASSERT(a_one_access, !(i_ctrl.clr && i_ctrl.we) && !(i_ctrl.re && i_ctrl.we))

endmodule

/* hdl/snap_frame_receiver_core.sv */
// Channel  | Dir | Handshake                   | Payload
// ---------+-----+-----------------------------+---------------------------------------
// s_axis   | in  | tvalid / tready             | tuser: opcode; tdata: rx_byte, read_index
// m_axis   | out | tvalid / tready, tlast      | tuser: kind; tdata: byte and status
// cfg      | in  | i_cfg_we (no back-pressure) | i_cfg_addr, i_cfg_wdata
//
// Flow: one item per cycle while the result stage is empty or drains, so m_axis
// back-pressure or an ack frame holds s_axis. An item is decoded and the frame state
// updated at the edge it is accepted; its result enters the result stage at that edge
// and the output register once that register is free. A completed frame with ack
// request emits six beats, holding the result stage until its last beat is loaded;
// every other item emits one beat. Payload reads go through the synchronous payload
// memory, registered alongside the result stage. Reset (i_rst_n low, synchronous)
// clears frame state, valid bits and config to defaults; no clearing pass.

`include "snap_frame_receiver_core_defines.svh"

module snap_frame_receiver_core
    import snapfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] rx_byte, [11:8] read_index, [15:12] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    // Result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] out_byte, [8] accepted, [9] packet_ready,
                                          // [10] header_error, [18:11] dest_address,
                                          // [26:19] source_address, [31:27] payload_length
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast,
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    localparam logic [BEAT_W-1:0] BEAT_SYNC = BEAT_W'(0);
    localparam logic [BEAT_W-1:0] BEAT_HDB2 = BEAT_W'(1);
    localparam logic [BEAT_W-1:0] BEAT_HDB1 = BEAT_W'(2);
    localparam logic [BEAT_W-1:0] BEAT_SRC  = BEAT_W'(3);
    localparam logic [BEAT_W-1:0] BEAT_DEST = BEAT_W'(4);
    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(ACK_BEATS - 1);

    // Result stage: everything one item needs to produce its beats.
    typedef struct packed {
        t_kind            kind;
        logic             accepted;
        logic             herr;
        logic             ready;
        logic [7:0]       dest;
        logic [7:0]       src;
        logic [LEN_W-1:0] len;
        logic [7:0]       sync;
        logic [7:0]       hdb2;
        logic [7:0]       crc;
    } t_s1;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data_byte;
        logic             last;
        logic             accepted;
        logic             herr;
        logic             ready;
        logic [7:0]       dest;
        logic [7:0]       src;
        logic [LEN_W-1:0] len;
    } t_out;

    // Config registers
    logic [7:0] r_own_addr, r_bcast_addr, r_sync_byte;

    // Frame state
    t_phase            r_phase, n_phase;
    logic              r_ack_req, n_ack_req;
    logic              r_ready, n_ready;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [7:0]        r_dest, n_dest;
    logic [7:0]        r_src, n_src;
    logic              r_ftn, n_ftn;
    logic [7:0]        r_crc, n_crc;
    logic [BIDX_W-1:0] r_bidx, n_bidx;

    t_s1               r_s1, n_s1;
    logic              r_s1_valid;
    logic [BEAT_W-1:0] r_beat;
    t_out              r_out, n_out;
    logic              r_out_valid;

    t_buf_ctrl  w_buf;
    logic [7:0] w_rd_byte;

    logic             w_in_acc;
    logic             w_out_load;
    logic             w_s1_done;
    logic [1:0]       w_op;
    logic [7:0]       w_c;
    logic [3:0]       w_ri;
    logic [LEN_W-1:0] w_len_raw;
    logic [LEN_W-1:0] w_len_cap;
    logic             w_dest_match;
    logic [7:0]       w_ack_crc;
    logic [7:0]       w_hdb2_sel;

    assign w_op = i_s_axis_tuser;
    assign w_c  = i_s_axis_tdata[7:0];
    assign w_ri = i_s_axis_tdata[11:8];

    // Take a new item whenever the result stage is empty or drains this cycle.
    assign w_out_load = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign w_s1_done  = w_out_load && ((r_s1.kind != KIND_ACK) || (r_beat == BEAT_LAST));
    assign o_s_axis_tready = !r_s1_valid || w_s1_done;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // Cap the raw length nibble at the buffer depth.
    assign w_len_raw = LEN_W'(w_c[3:0]);
    assign w_len_cap = (w_len_raw > LEN_W'(PAYLOAD_DEPTH)) ? LEN_W'(PAYLOAD_DEPTH) : w_len_raw;
    assign w_dest_match = (w_c == r_bcast_addr) || (w_c == r_own_addr);

    // Ack frame CRC covers hdb2, hdb1, source and dest.
    assign w_hdb2_sel = (w_c == r_crc) ? ACK_HDB2 : NAK_HDB2;
    assign w_ack_crc  = crc8_update(crc8_update(crc8_update(crc8_update(8'h00, w_hdb2_sel),
                                    ACK_HDB1), r_src), r_dest);

    // Decode the accepted item: next frame state, memory access, result descriptor.
    always_comb begin
        logic do_clear;
        logic herr;
        logic refused;
        logic send_ack;
        do_clear  = 1'b0;
        herr      = 1'b0;
        refused   = 1'b0;
        send_ack  = 1'b0;
        n_phase   = r_phase;
        n_ack_req = r_ack_req;
        n_ready   = r_ready;
        n_len     = r_len;
        n_dest    = r_dest;
        n_src     = r_src;
        n_ftn     = r_ftn;
        n_crc     = r_crc;
        n_bidx    = r_bidx;
        w_buf       = '0;
        w_buf.wdata = w_c;
        w_buf.ridx  = w_ri;
        w_buf.rd_ok = (LEN_W'(w_ri) < LEN_W'(PAYLOAD_DEPTH));
        w_buf.widx  = r_bidx[IDX_W-1:0];
        n_s1.kind   = KIND_STATUS;

        if (w_in_acc) begin
            unique case (w_op)
                OP_RELEASE: begin
                    do_clear = 1'b1;
                end
                OP_READ: begin
                    w_buf.re  = 1'b1;
                    n_s1.kind = KIND_READ;
                end
                OP_RX: begin
                    if (r_ready) begin
                        refused = 1'b1;
                    end else begin
                        unique case (r_phase)
                            PH_IDLE: begin
                                if (w_c == r_sync_byte) begin
                                    n_phase = PH_SYNC;
                                end
                            end
                            PH_SYNC: begin
                                if ((w_c & HDB2_MASK) != HDB2_VAL) begin
                                    do_clear = 1'b1;
                                    herr     = 1'b1;
                                end else begin
                                    n_ack_req = (w_c[1:0] == ACK_REQ_CODE);
                                    n_crc     = crc8_update(8'h00, w_c);
                                    n_phase   = PH_HDB2;
                                end
                            end
                            PH_HDB2: begin
                                if ((w_c & HDB1_MASK) != HDB1_VAL) begin
                                    do_clear = 1'b1;
                                    herr     = 1'b1;
                                end else begin
                                    n_len   = w_len_cap;
                                    n_crc   = crc8_update(r_crc, w_c);
                                    n_phase = PH_HDB1;
                                end
                            end
                            PH_HDB1: begin
                                n_dest = w_c;
                                n_ftn  = w_dest_match;
                                if (w_dest_match) begin
                                    n_crc = crc8_update(r_crc, w_c);
                                end
                                n_phase = PH_DAB;
                            end
                            PH_DAB: begin
                                n_src  = w_c;
                                n_bidx = '0;
                                if (r_ftn) begin
                                    n_crc = crc8_update(r_crc, w_c);
                                end
                                n_phase = (r_len == '0) ? PH_CRC : PH_DATA;
                            end
                            PH_DATA: begin
                                if (r_ftn) begin
                                    w_buf.we = (r_bidx < BIDX_W'(PAYLOAD_DEPTH));
                                    n_crc    = crc8_update(r_crc, w_c);
                                end
                                n_bidx = r_bidx + 1'b1;
                                if (n_bidx == r_len) begin
                                    n_phase = PH_CRC;
                                end
                            end
                            PH_CRC: begin
                                if (r_ftn) begin
                                    if (w_c == r_crc) begin
                                        n_ready = 1'b1;
                                    end
                                    if (r_ack_req) begin
                                        send_ack  = 1'b1;
                                        n_ack_req = 1'b0;
                                    end
                                end
                                n_phase = PH_IDLE;
                            end
                            default: begin
                                do_clear = 1'b1;
                                herr     = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                    // Unused opcode: status only.
                end
            endcase
        end

        // Drop the frame: for_this_node keeps its value.
        if (do_clear) begin
            n_phase   = PH_IDLE;
            n_ack_req = 1'b0;
            n_ready   = 1'b0;
            n_len     = '0;
            n_dest    = '0;
            n_src     = '0;
            n_crc     = '0;
            n_bidx    = '0;
            w_buf.clr = 1'b1;
        end

        if (send_ack) begin
            n_s1.kind = KIND_ACK;
        end
        n_s1.accepted = !refused;
        n_s1.herr     = herr;
        n_s1.ready    = n_ready;
        n_s1.dest     = n_dest;
        n_s1.src      = n_src;
        n_s1.len      = n_len;
        n_s1.sync     = r_sync_byte;
        n_s1.hdb2     = w_hdb2_sel;
        n_s1.crc      = w_ack_crc;
    end

    snapfr_payload_buf u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_buf),
        .o_rd_byte (w_rd_byte)
    );

    // Build the next output beat from the result stage.
    always_comb begin
        n_out.kind      = r_s1.kind;
        n_out.accepted  = r_s1.accepted;
        n_out.herr      = r_s1.herr;
        n_out.ready     = r_s1.ready;
        n_out.dest      = r_s1.dest;
        n_out.src       = r_s1.src;
        n_out.len       = r_s1.len;
        n_out.last      = 1'b1;
        n_out.data_byte = 8'h00;
        unique case (r_s1.kind)
            KIND_ACK: begin
                n_out.last = (r_beat == BEAT_LAST);
                unique case (r_beat)
                    BEAT_SYNC: n_out.data_byte = r_s1.sync;
                    BEAT_HDB2: n_out.data_byte = r_s1.hdb2;
                    BEAT_HDB1: n_out.data_byte = ACK_HDB1;
                    BEAT_SRC:  n_out.data_byte = r_s1.src;
                    BEAT_DEST: n_out.data_byte = r_s1.dest;
                    default:   n_out.data_byte = r_s1.crc;
                endcase
            end
            KIND_READ: begin
                n_out.data_byte = w_rd_byte;
            end
            default: begin
                n_out.data_byte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr   <= 8'd1;
            r_bcast_addr <= 8'd0;
            r_sync_byte  <= 8'h54;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_OWN_ADDR:   r_own_addr   <= i_cfg_wdata;
                CFG_BCAST_ADDR: r_bcast_addr <= i_cfg_wdata;
                CFG_SYNC_BYTE:  r_sync_byte  <= i_cfg_wdata;
                default: begin
                    // Index past the register list: ignore.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ack_req   <= 1'b0;
            r_ready     <= 1'b0;
            r_len       <= '0;
            r_dest      <= '0;
            r_src       <= '0;
            r_ftn       <= 1'b0;
            r_crc       <= '0;
            r_bidx      <= '0;
            r_s1_valid  <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_ack_req <= n_ack_req;
            r_ready   <= n_ready;
            r_len     <= n_len;
            r_dest    <= n_dest;
            r_src     <= n_src;
            r_ftn     <= n_ftn;
            r_crc     <= n_crc;
            r_bidx    <= n_bidx;

            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_done) begin
                r_s1_valid <= 1'b0;
            end

            // Advance the ack beat counter; reset it once the stage drains.
            if (w_s1_done) begin
                r_beat <= '0;
            end else if (w_out_load) begin
                r_beat <= r_beat + 1'b1;
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= n_s1;
        end
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {r_out.len, r_out.src, r_out.dest, r_out.herr,
                              r_out.ready, r_out.accepted, r_out.data_byte};

    `SNAPFR_ASSERT(a_beat_only_ack, (r_beat != '0) |-> (r_s1_valid && (r_s1.kind == KIND_ACK)))
    `SNAPFR_ASSERT(a_refuse_pending, (r_out_valid && !r_out.accepted) |-> r_out.ready)
    `SNAPFR_ASSERT(a_herr_cleared, (r_out_valid && r_out.herr) |-> (!r_out.ready && (r_out.len == '0)))

endmodule

/* bench/snap_frame_receiver_checker.sv */
`timescale 1ns / 1ps

// Watches both streams and the register port of the SNAP receiver, keeps its own
// copy of the frame state, and checks every result beat against the oldest one due.
module snap_frame_receiver_checker
    import snapfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,
    input  logic [1:0]  i_m_axis_tuser,
    input  logic        i_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data;
        logic             last;
        logic             accepted;
        logic             ready;
        logic             herr;
        logic [7:0]       dest;
        logic [7:0]       src;
        logic [LEN_W-1:0] len;
    } rx_beat_t;

    rx_beat_t replies_due[$];
    int       fails = 0;

    // node settings
    logic [7:0] node_addr;
    logic [7:0] bcast_addr;
    logic [7:0] sync_val;

    // frame state
    t_phase              rx_phase;
    logic                ack_wanted;
    logic                pkt_ready;
    logic [LEN_W-1:0]    frm_len;
    logic [7:0]          frm_dest;
    logic [7:0]          frm_src;
    logic                for_me;
    logic [7:0]          run_crc;
    logic [BIDX_W-1:0]   data_idx;
    logic [7:0]          payload [PAYLOAD_DEPTH];
    logic [PAYLOAD_DEPTH-1:0] payload_valid;

    // Dallas/Maxim CRC-8, shifted out one bit at a time
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8c) : (c >> 1);
        end
        return c;
    endfunction

    // drop the frame; for_me survives on purpose
    task automatic drop_frame();
        rx_phase      = PH_IDLE;
        ack_wanted    = 1'b0;
        pkt_ready     = 1'b0;
        frm_len       = '0;
        frm_dest      = '0;
        frm_src       = '0;
        run_crc       = '0;
        data_idx      = '0;
        payload_valid = '0;
    endtask

    function automatic rx_beat_t status_beat(input t_kind kind, input logic [7:0] data,
                                             input logic last, input logic acc,
                                             input logic herr);
        rx_beat_t r;
        r.kind     = kind;
        r.data     = data;
        r.last     = last;
        r.accepted = acc;
        r.ready    = pkt_ready;
        r.herr     = herr;
        r.dest     = frm_dest;
        r.src      = frm_src;
        r.len      = frm_len;
        return r;
    endfunction

    task automatic advance_receiver(input logic [1:0] op, input logic [7:0] rx,
                                    input logic [IDX_W-1:0] ridx);
        logic       herr;
        logic       send_ack;
        logic [7:0] reply [ACK_BEATS];
        logic [7:0] rcrc;
        logic [7:0] rdata;
        herr     = 1'b0;
        send_ack = 1'b0;
        case (op)
            OP_RELEASE: begin
                drop_frame();
                replies_due.push_back(status_beat(KIND_STATUS, 8'h00, 1'b1, 1'b1, 1'b0));
            end
            OP_READ: begin
                rdata = 8'h00;
                if (int'(ridx) < PAYLOAD_DEPTH && payload_valid[ridx]) begin
                    rdata = payload[ridx];
                end
                replies_due.push_back(status_beat(KIND_READ, rdata, 1'b1, 1'b1, 1'b0));
            end
            OP_RX: begin
                if (pkt_ready) begin
                    // refused, nothing moves
                    replies_due.push_back(status_beat(KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b0));
                end else begin
                    case (rx_phase)
                        PH_IDLE: begin
                            if (rx == sync_val) begin
                                rx_phase = PH_SYNC;
                            end
                        end
                        PH_SYNC: begin
                            if ((rx & HDB2_MASK) != HDB2_VAL) begin
                                drop_frame();
                                herr = 1'b1;
                            end else begin
                                ack_wanted = (rx[1:0] == ACK_REQ_CODE);
                                run_crc    = crc8_step(8'h00, rx);
                                rx_phase   = PH_HDB2;
                            end
                        end
                        PH_HDB2: begin
                            if ((rx & HDB1_MASK) != HDB1_VAL) begin
                                drop_frame();
                                herr = 1'b1;
                            end else begin
                                frm_len  = (rx[3:0] > PAYLOAD_DEPTH) ? LEN_W'(PAYLOAD_DEPTH)
                                                                     : LEN_W'(rx[3:0]);
                                run_crc  = crc8_step(run_crc, rx);
                                rx_phase = PH_HDB1;
                            end
                        end
                        PH_HDB1: begin
                            frm_dest = rx;
                            for_me   = (rx == bcast_addr) || (rx == node_addr);
                            if (for_me) begin
                                run_crc = crc8_step(run_crc, rx);
                            end
                            rx_phase = PH_DAB;
                        end
                        PH_DAB: begin
                            frm_src  = rx;
                            data_idx = '0;
                            if (for_me) begin
                                run_crc = crc8_step(run_crc, rx);
                            end
                            rx_phase = (frm_len == 0) ? PH_CRC : PH_DATA;
                        end
                        PH_DATA: begin
                            if (for_me) begin
                                if (int'(data_idx) < PAYLOAD_DEPTH) begin
                                    payload[data_idx[IDX_W-1:0]]       = rx;
                                    payload_valid[data_idx[IDX_W-1:0]] = 1'b1;
                                end
                                run_crc = crc8_step(run_crc, rx);
                            end
                            data_idx = data_idx + 1'b1;
                            if (data_idx == frm_len) begin
                                rx_phase = PH_CRC;
                            end
                        end
                        PH_CRC: begin
                            if (for_me) begin
                                reply[1] = (rx == run_crc) ? ACK_HDB2 : NAK_HDB2;
                                if (rx == run_crc) begin
                                    pkt_ready = 1'b1;
                                end
                                if (ack_wanted) begin
                                    reply[0] = sync_val;
                                    reply[2] = ACK_HDB1;
                                    reply[3] = frm_src;
                                    reply[4] = frm_dest;
                                    rcrc     = 8'h00;
                                    for (int k = 1; k < 5; k++) begin
                                        rcrc = crc8_step(rcrc, reply[k]);
                                    end
                                    reply[5]   = rcrc;
                                    send_ack   = 1'b1;
                                    ack_wanted = 1'b0;
                                end
                            end
                            rx_phase = PH_IDLE;
                        end
                        default: begin
                            drop_frame();
                            herr = 1'b1;
                        end
                    endcase
                    if (send_ack) begin
                        for (int k = 0; k < ACK_BEATS; k++) begin
                            replies_due.push_back(status_beat(KIND_ACK, reply[k],
                                                              k == ACK_BEATS - 1, 1'b1, 1'b0));
                        end
                    end else begin
                        replies_due.push_back(status_beat(KIND_STATUS, 8'h00, 1'b1, 1'b1, herr));
                    end
                end
            end
            default: begin
                replies_due.push_back(status_beat(KIND_STATUS, 8'h00, 1'b1, 1'b1, 1'b0));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        rx_beat_t got;
        rx_beat_t want;
        if (!i_rst_n) begin
            node_addr  = 8'h01;
            bcast_addr = 8'h00;
            sync_val   = 8'h54;
            for_me     = 1'b0;
            drop_frame();
            replies_due.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.kind     = t_kind'(i_m_axis_tuser);
                got.data     = i_m_axis_tdata[7:0];
                got.last     = i_m_axis_tlast;
                got.accepted = i_m_axis_tdata[8];
                got.ready    = i_m_axis_tdata[9];
                got.herr     = i_m_axis_tdata[10];
                got.dest     = i_m_axis_tdata[18:11];
                got.src      = i_m_axis_tdata[26:19];
                got.len      = i_m_axis_tdata[31:27];
                if (replies_due.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t: result beat with nothing due: kind %0d byte %02h",
                                 $time, got.kind, got.data);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $write("%0t: beat differs (expected/actual): kind %0d/%0d ",
                                   $time, want.kind, got.kind);
                            $write("byte %02h/%02h last %0b/%0b acc %0b/%0b ",
                                   want.data, got.data, want.last, got.last,
                                   want.accepted, got.accepted);
                            $write("ready %0b/%0b herr %0b/%0b dest %02h/%02h ",
                                   want.ready, got.ready, want.herr, got.herr,
                                   want.dest, got.dest);
                            $display("src %02h/%02h len %0d/%0d",
                                     want.src, got.src, want.len, got.len);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_OWN_ADDR:   node_addr  = i_cfg_wdata;
                    CFG_BCAST_ADDR: bcast_addr = i_cfg_wdata;
                    CFG_SYNC_BYTE:  sync_val   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                advance_receiver(i_s_axis_tuser, i_s_axis_tdata[7:0], i_s_axis_tdata[11:8]);
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= fails;
    end

endmodule

/* bench/tb_snap_frame_receiver_core.sv */
`timescale 1ns / 1ps

module tb_snap_frame_receiver_core;
    import snapfr_pkg::*;

    localparam realtime    CLK_PERIOD     = 12ns;
    localparam int         RESET_CYCLES   = 4;
    localparam int         PHASE_ITEMS    = 112;
    localparam int         LONG_HOLD      = 120;   // receiver hold-off, well past the pipe depth
    localparam int         WATCHDOG_LIMIT = 3000;  // cycles without any item moving
    localparam int         END_WAIT       = 20;    // two-stage pipe plus a margin
    localparam logic [1:0] OP_IGNORED     = 2'd3;  // unused opcode, answered with status

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [15:0] i_s_axis_tdata  = '0;   // [7:0] rx_byte, [11:8] read_index, [15:12] zero
    logic [1:0]  i_s_axis_tuser  = '0;   // [1:0] opcode
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_addr      = '0;
    logic [7:0]  i_cfg_wdata     = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;         // [7:0] out_byte, [8] accepted, [9] packet_ready,
                                         // [10] header_error, [18:11] dest_address,
                                         // [26:19] source_address, [31:27] payload_length
    logic [1:0]  o_m_axis_tuser;         // [1:0] kind
    logic        o_m_axis_tlast;

    int chk_fails;
    int chk_pending;

    // stimulus knobs
    int         src_idle_pct = 0;
    int         dst_idle_pct = 0;
    int         items_sent   = 0;
    logic       pressure_on  = 1'b0;
    logic       held_once    = 1'b0;
    int         hold_left    = 0;
    int         quiet_cycles = 0;

    // what the stimulus believes the node settings are, to build frames that land
    logic [7:0] cur_own  = 8'h01;
    logic [7:0] cur_bcast = 8'h00;
    logic [7:0] cur_sync = 8'h54;

    wire s_acc = i_s_axis_tvalid && o_s_axis_tready;
    wire m_acc = o_m_axis_tvalid && i_m_axis_tready;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    snap_frame_receiver_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    snap_frame_receiver_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (chk_fails),
        .o_pending       (chk_pending)
    );

    // Result side: random back-pressure at dst_idle_pct, plus one long hold-off
    // in the pressure phase so the pipe fills and the input stalls behind it.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (pressure_on && !held_once && s_acc) begin
            held_once       <= 1'b1;
            hold_left       <= LONG_HOLD;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // Abort when no item moves on either stream for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || s_acc || m_acc) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("snap_frame_receiver_core: mismatch");
            $finish;
        end
    end

    // CRC the sender puts on its frames (shift-right form, poly 0x8c reflected)
    function automatic logic [7:0] snap_crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8c) : (c >> 1);
        end
        return c;
    endfunction

    // Offer one item after a random gap, hold it until it is taken.
    task automatic send_item(input logic [1:0] op, input logic [7:0] rxb,
                             input logic [3:0] ridx);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {4'b0000, ridx, rxb};
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        if (op != OP_IGNORED) begin
            items_sent++;
        end
    endtask

    // read_index is don't-care for a received byte, so toggle it anyway
    task automatic send_rx(input logic [7:0] b);
        send_item(OP_RX, b, 4'($urandom));
    endtask

    // One complete frame: sync, hdb2, hdb1, dest, src, payload, crc.
    task automatic send_frame(input logic want_ack, input int len, input logic [7:0] dest,
                              input logic crc_good);
        logic [1:0] ack_code;
        logic [7:0] hdb2;
        logic [7:0] hdb1;
        logic [7:0] src;
        logic [7:0] pb;
        logic [7:0] crc;
        ack_code = ACK_REQ_CODE;
        if (!want_ack) begin
            do begin
                ack_code = 2'($urandom);
            end while (ack_code == ACK_REQ_CODE);
        end
        hdb2 = HDB2_VAL | {6'b0, ack_code};
        hdb1 = HDB1_VAL | 8'(len);
        src  = 8'($urandom);
        send_rx(cur_sync);
        crc = snap_crc_byte(8'h00, hdb2);
        send_rx(hdb2);
        crc = snap_crc_byte(crc, hdb1);
        send_rx(hdb1);
        crc = snap_crc_byte(crc, dest);
        send_rx(dest);
        crc = snap_crc_byte(crc, src);
        send_rx(src);
        for (int k = 0; k < len; k++) begin
            pb  = 8'($urandom);
            crc = snap_crc_byte(crc, pb);
            send_rx(pb);
        end
        send_rx(crc_good ? crc : (crc ^ 8'($urandom_range(1, 255))));
    endtask

    // Stop offering and hold until every due result has been taken.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Reprogram the node; only called with the pipe drained.
    task automatic set_node(input logic [7:0] own, input logic [7:0] bcast,
                            input logic [7:0] sync);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_OWN_ADDR;
        i_cfg_wdata <= own;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_BCAST_ADDR;
        i_cfg_wdata <= bcast;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SYNC_BYTE;
        i_cfg_wdata <= sync;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_own   = own;
        cur_bcast = bcast;
        cur_sync  = sync;
    endtask

    // Random traffic: mostly clean frames with random content, mixed with broken
    // headers and truncated frames and with raw noise on every opcode.
    task automatic run_traffic(input int src_pct, input int dst_pct, input int count);
        int         target;
        int         pick;
        int         len;
        logic [7:0] dest;
        logic [7:0] bad;
        src_idle_pct = src_pct;
        dst_idle_pct <= dst_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                // release first most of the time so the frame starts from idle
                if ($urandom_range(9) < 7) begin
                    send_item(OP_RELEASE, 8'($urandom), 4'($urandom));
                end
                pick = $urandom_range(99);
                dest = (pick < 40) ? cur_own : (pick < 65) ? cur_bcast : 8'($urandom);
                len  = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(4);
                send_frame($urandom_range(9) < 6, len, dest, $urandom_range(99) < 85);
                // stray bytes get refused while a packet waits
                repeat ($urandom_range(2)) send_rx(8'($urandom));
                repeat ($urandom_range(3)) send_item(OP_READ, 8'($urandom), 4'($urandom));
            end else if (pick < 75) begin
                if ($urandom_range(1) == 0) begin
                    send_item(OP_RELEASE, 8'($urandom), 4'($urandom));
                end
                send_rx(cur_sync);
                case ($urandom_range(2))
                    0: begin
                        do begin
                            bad = 8'($urandom);
                        end while ((bad & HDB2_MASK) == HDB2_VAL);
                        send_rx(bad);
                    end
                    1: begin
                        send_rx(HDB2_VAL | 8'($urandom_range(3)));
                        do begin
                            bad = 8'($urandom);
                        end while ((bad & HDB1_MASK) == HDB1_VAL);
                        send_rx(bad);
                    end
                    default: begin
                        // truncated: header and address only
                        send_rx(HDB2_VAL | 8'($urandom_range(3)));
                        send_rx(HDB1_VAL | 8'($urandom_range(15)));
                        send_rx($urandom_range(1) ? cur_own : 8'($urandom));
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(2'($urandom), 8'($urandom), 4'($urandom));
                end
            end
            // now and then let the pipe run dry
            if ($urandom_range(19) == 0) begin
                drain();
            end
        end
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass with the reset settings.
        // Good frame with ack request: six-beat ACK, packet left pending.
        send_frame(1'b1, 1, cur_own, 1'b1);
        // byte while the packet waits: refused
        send_rx(8'hff);
        // read a stored entry and one never written
        send_item(OP_READ, 8'h00, 4'd0);
        send_item(OP_READ, 8'hff, 4'd15);
        send_item(OP_IGNORED, 8'h00, 4'd0);
        send_item(OP_RELEASE, 8'h00, 4'd0);
        // bad hdb2, then bad hdb1
        send_rx(cur_sync);
        send_rx(8'h00);
        send_rx(cur_sync);
        send_rx(HDB2_VAL);
        send_rx(8'hff);
        // empty broadcast frame with a wrong CRC: NAK
        send_frame(1'b1, 0, cur_bcast, 1'b0);

        // Sender sparse, receiver busy.
        run_traffic(34, 77, PHASE_ITEMS);

        // Extremes: own and broadcast the same all-ones address, sync zero.
        set_node(8'hff, 8'hff, 8'h00);
        run_traffic(77, 34, PHASE_ITEMS);

        // Own address zero, sync all ones; no idling, one long hold-off.
        set_node(8'h00, 8'h7e, 8'hff);
        pressure_on <= 1'b1;
        run_traffic(0, 0, PHASE_ITEMS);

        repeat (END_WAIT) @(posedge i_clk);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("snap_frame_receiver_core: match");
        end else begin
            $display("snap_frame_receiver_core: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/snapfr_pkg.sv
hdl/snapfr_payload_buf.sv
hdl/snap_frame_receiver_core.sv
bench/snap_frame_receiver_checker.sv
bench/tb_snap_frame_receiver_core.sv
